@@ rtl/mbcb_pkg.sv @@
package mbcb_pkg;

    localparam int BYTE_W      = 8;
    localparam int WIN_W       = 16;
    localparam int LEN_W       = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;

    localparam int RESULT_DEPTH = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK_LENGTH = 2'd1;

    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RESET    = 16'd8192;
    localparam logic [LEN_W-1:0] MAX_CHUNK_LENGTH_RESET = 18'd33792;

    typedef struct packed {
        logic [WIN_W-1:0] window_length;
        logic [LEN_W-1:0] max_chunk_length;
    } cfg_regs_t;

    typedef struct packed {
        logic [LEN_W-1:0] chunk_length;
        logic             stream_final;
        logic             run_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } result_push_t;

endpackage

@@ rtl/mbcb_if.sv @@
interface mbcb_byte_if;
    logic                         valid;
    logic                         ready;
    logic [mbcb_pkg::BYTE_W-1:0] data_byte;
    logic                         end_of_data;

    modport source (output valid, data_byte, end_of_data, input ready);
    modport sink   (input valid, data_byte, end_of_data, output ready);
endinterface

interface mbcb_chunk_if;
    logic                        valid;
    logic                        ready;
    logic [mbcb_pkg::LEN_W-1:0] chunk_length;
    logic                        stream_final;
    logic                        run_last;

    modport source (output valid, chunk_length, stream_final, run_last, input ready);
    modport sink   (input valid, chunk_length, stream_final, run_last, output ready);
endinterface

interface mbcb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mbcb_pkg::CFG_INDEX_W-1:0] index;
    logic [mbcb_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/mbcb_cfg_regs.sv @@
module mbcb_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    mbcb_cfg_if.sink            cfg,
    output mbcb_pkg::cfg_regs_t regs
);
    import mbcb_pkg::*;

    logic [WIN_W-1:0] window_length_reg;
    logic [WIN_W-1:0] window_length_next;
    logic [LEN_W-1:0] max_chunk_length_reg;
    logic [LEN_W-1:0] max_chunk_length_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        window_length_next    = window_length_reg;
        max_chunk_length_next = max_chunk_length_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WINDOW_LENGTH:    window_length_next    = cfg.data[WIN_W-1:0];
                REG_MAX_CHUNK_LENGTH: max_chunk_length_next = cfg.data[LEN_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg    <= WINDOW_LENGTH_RESET;
            max_chunk_length_reg <= MAX_CHUNK_LENGTH_RESET;
        end
        else
        begin
            window_length_reg    <= window_length_next;
            max_chunk_length_reg <= max_chunk_length_next;
        end
    end

    assign regs.window_length    = window_length_reg;
    assign regs.max_chunk_length = max_chunk_length_reg;

endmodule

@@ rtl/mbcb_core.sv @@
module mbcb_core (
    input  logic                   clk,
    input  logic                   rst_n,
    mbcb_byte_if.sink              byte_stream,
    input  mbcb_pkg::cfg_regs_t    regs,
    input  logic                   room,
    output mbcb_pkg::result_push_t push
);
    import mbcb_pkg::*;

    logic              item_valid_reg;
    logic              item_valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              eod_reg;
    logic [LEN_W-1:0]  position_reg;
    logic [LEN_W-1:0]  position_next;
    logic [BYTE_W-1:0] maximum_reg;
    logic [BYTE_W-1:0] maximum_next;

    logic              accept;
    logic              fire;
    logic [LEN_W-1:0]  win;
    logic [LEN_W-1:0]  cap;
    logic              cut_first;
    logic              cut_second;
    logic [LEN_W-1:0]  position_a;
    logic [BYTE_W-1:0] maximum_a;
    logic [BYTE_W-1:0] maximum_b;
    logic [LEN_W-1:0]  position_b;
    out_item_t         close_item;

    assign fire              = item_valid_reg && room;
    assign byte_stream.ready = !item_valid_reg || fire;
    assign accept            = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        win = (regs.window_length == '0) ? LEN_W'(1) : LEN_W'(regs.window_length);
        cap = (regs.max_chunk_length == '0) ? LEN_W'(1) : regs.max_chunk_length;

        cut_first = (position_reg >= cap) ||
                    (position_reg >= win && data_reg >= maximum_reg);
        position_a = cut_first ? '0 : position_reg;
        maximum_a  = cut_first ? '0 : maximum_reg;
        maximum_b  = (position_a < win && data_reg > maximum_a) ? data_reg : maximum_a;
        position_b = position_a + LEN_W'(1);
        cut_second = (position_b >= cap) || eod_reg;

        close_item.chunk_length = position_b;
        close_item.stream_final = eod_reg;
        close_item.run_last     = 1'b1;

        push.count  = 2'd0;
        push.first  = close_item;
        push.second = close_item;
        if (fire)
        begin
            push.count = {1'b0, cut_first} + {1'b0, cut_second};
            if (cut_first)
            begin
                push.first.chunk_length = position_reg;
                push.first.stream_final = 1'b0;
                push.first.run_last     = !cut_second;
            end
        end

        item_valid_next = accept ? 1'b1 : (fire ? 1'b0 : item_valid_reg);
        position_next   = position_reg;
        maximum_next    = maximum_reg;
        if (fire)
        begin
            position_next = cut_second ? '0 : position_b;
            maximum_next  = cut_second ? '0 : maximum_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            position_reg   <= '0;
            maximum_reg    <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            position_reg   <= position_next;
            maximum_reg    <= maximum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= byte_stream.data_byte;
            eod_reg  <= byte_stream.end_of_data;
        end
    end

    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> fire)
        else $error("results pushed without a byte in process");

    a_two_results_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.run_last && push.second.run_last &&
                               !push.first.stream_final)
        else $error("bad run_last or stream_final on a pair of results");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eod_reg |=> position_reg == '0 && maximum_reg == '0)
        else $error("state not cleared after end of stream");

    a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && eod_reg |-> push.count != 2'd0)
        else $error("final byte closed no chunk");

endmodule

@@ rtl/mbcb_result_fifo.sv @@
module mbcb_result_fifo #(
    parameter int DEPTH = mbcb_pkg::RESULT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mbcb_pkg::result_push_t push,
    output logic                   room,
    mbcb_chunk_if.source           chunks
);
    import mbcb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    out_item_t       mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   wr_ptr_plus1;
    logic [AW-1:0]   wr_ptr_plus2;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;
    out_item_t       head;

    assign room = count_reg <= CW'(DEPTH - 2);
    assign pop  = chunks.valid && chunks.ready;

    always_comb
    begin
        wr_ptr_plus1 = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        wr_ptr_plus2 = (wr_ptr_plus1 == AW'(DEPTH - 1)) ? '0 : wr_ptr_plus1 + AW'(1);
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wr_ptr_plus2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    assign head                = mem[rd_ptr_reg];
    assign chunks.valid        = count_reg != '0;
    assign chunks.chunk_length = head.chunk_length;
    assign chunks.stream_final = head.stream_final;
    assign chunks.run_last     = head.run_last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> room)
        else $error("results pushed without room");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 count_reg == $past(count_reg) + CW'($past(push.count)) - CW'($past(pop)))
        else $error("queue count out of step with beats");

endmodule

@@ rtl/max_byte_chunk_boundary_top.sv @@
// Channel      Dir   Beat contents
// byte_stream  in    data_byte[7:0], end_of_data
// chunks       out   chunk_length[17:0], stream_final, run_last
// cfg          in    index[1:0] (0 window_length, 1 max_chunk_length), data[17:0]
//
// One byte enters per cycle unless stalled; its chunk closes are pushed from a register.
// A byte closing two chunks pushes two beats; the queue drains one per cycle while ready.
// byte_stream stalls only while the queue has fewer than two free entries.
// Reset clears chunk position and window maximum and loads the register defaults.
// cfg is always ready; write it only while no byte is in flight.
module max_byte_chunk_boundary_top #(
    parameter int RESULT_DEPTH = mbcb_pkg::RESULT_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    mbcb_byte_if.sink    byte_stream,
    mbcb_chunk_if.source chunks,
    mbcb_cfg_if.sink     cfg
);
    import mbcb_pkg::*;

    cfg_regs_t    regs;
    result_push_t push;
    logic         room;

    mbcb_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mbcb_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .regs        (regs),
        .room        (room),
        .push        (push)
    );

    mbcb_result_fifo #(
        .DEPTH (RESULT_DEPTH)
    ) u_result_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .chunks (chunks)
    );

endmodule
